FILE: hw/rtl/smps_pkg.sv
package smps_pkg;

	localparam int MAX_PEOPLE = 128;
	localparam int PROB_BITS  = 16;
	localparam int IDX_W      = $clog2(MAX_PEOPLE);
	localparam int CNT_W      = 8;
	localparam int THR_W      = PROB_BITS + 1;

	localparam logic [1:0] PS_SUSC = 2'd0;
	localparam logic [1:0] PS_INF  = 2'd1;
	localparam logic [1:0] PS_REC  = 2'd2;

	localparam logic [1:0] REQ_UPDATE  = 2'd0;
	localparam logic [1:0] REQ_TICK    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [1:0] CFG_POP_SIZE  = 2'd0;
	localparam logic [1:0] CFG_INIT_INF  = 2'd1;
	localparam logic [1:0] CFG_INF_BASE  = 2'd2;
	localparam logic [1:0] CFG_REC_STAY  = 2'd3;

	localparam logic [CNT_W-1:0]     RST_POP_SIZE = CNT_W'(100);
	localparam logic [CNT_W-1:0]     RST_INIT_INF = CNT_W'(1);
	localparam logic [PROB_BITS-1:0] RST_INF_BASE = PROB_BITS'(65513);
	localparam logic [PROB_BITS-1:0] RST_REC_STAY = PROB_BITS'(65209);
	// With one person infected at reset the threshold is the base itself.
	localparam logic [THR_W-1:0]     RST_THRESHOLD = {1'b0, RST_INF_BASE};
	localparam logic [THR_W-1:0]     PROB_ONE = {1'b1, {PROB_BITS{1'b0}}};

	typedef struct packed {
		logic [1:0]  req_type;
		logic [6:0]  person_index;
		logic [15:0] draw;
	} req_word_t;

	typedef struct packed {
		logic [1:0] person_state;
		logic [7:0] count_susceptible;
		logic [7:0] count_infected;
		logic [7:0] count_recovered;
		logic       bad_index;
	} rsp_word_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_UPDATE,
		CS_MUL,
		CS_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic commit;
		logic mul_step;
		logic thr_load;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic mul_done;
	} dp_status_t;

endpackage

FILE: hw/rtl/smps_ram.sv
module smps_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/smps_ctrl.sv
module smps_ctrl import smps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       req_stall
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (req_valid) begin
					if (req_type == REQ_UPDATE) begin
						state_d = CS_UPDATE;
					end else if (req_type == REQ_TICK || req_type == REQ_RESTART) begin
						state_d = CS_MUL;
					end else begin
						state_d = CS_FINISH;
					end
				end
			end
			CS_UPDATE: begin
				if (status.out_free) state_d = CS_IDLE;
			end
			CS_MUL: begin
				if (status.mul_done) state_d = CS_FINISH;
			end
			CS_FINISH: begin
				if (status.out_free) state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		unique case (state_q)
			CS_IDLE: begin
				req_stall = 1'b0;
				cmd.accept = req_valid;
			end
			CS_UPDATE: cmd.commit = status.out_free;
			CS_MUL: begin
				cmd.mul_step = !status.mul_done;
				cmd.thr_load = status.mul_done;
			end
			CS_FINISH: cmd.finish = status.out_free;
			default: req_stall = 1'b1;
		endcase
	end

endmodule

FILE: hw/rtl/smps_dp.sv
module smps_dp import smps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  req_word_t            req,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	output rsp_word_t            rsp,
	output logic                 rsp_valid,
	input  logic                 rsp_stall
);

	logic [CNT_W-1:0]     pop_size_q, init_inf_q;
	logic [PROB_BITS-1:0] inf_base_q, rec_stay_q;
	logic [CNT_W-1:0]     active_q, kinit_q;
	logic [CNT_W-1:0]     cnt_s_q, cnt_i_q, cnt_r_q;
	logic [CNT_W-1:0]     cnt_s_d, cnt_i_d, cnt_r_d;
	logic [THR_W-1:0]     thr_q, t_q;
	logic [CNT_W-1:0]     step_q;
	logic [MAX_PEOPLE-1:0] valid_q;
	logic [IDX_W-1:0]     idx_q;
	logic [PROB_BITS-1:0] draw_q;
	logic [CNT_W-1:0]     p_new, k_new, idx_ext;
	logic [IDX_W-1:0]     ram_raddr;
	logic [1:0]           ram_rdata, cur_state, new_state;
	logic                 bad, ram_we;
	logic [THR_W+PROB_BITS-1:0] product;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_size_q <= RST_POP_SIZE;
			init_inf_q <= RST_INIT_INF;
			inf_base_q <= RST_INF_BASE;
			rec_stay_q <= RST_REC_STAY;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_POP_SIZE: pop_size_q <= cfg_data[CNT_W-1:0];
				CFG_INIT_INF: init_inf_q <= cfg_data[CNT_W-1:0];
				CFG_INF_BASE: inf_base_q <= cfg_data;
				CFG_REC_STAY: rec_stay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign p_new = (pop_size_q > CNT_W'(MAX_PEOPLE)) ? CNT_W'(MAX_PEOPLE) : pop_size_q;
	assign k_new = (init_inf_q > p_new) ? p_new : init_inf_q;

	assign ram_raddr = cmd.accept ? req.person_index : idx_q;
	assign idx_ext   = {{(CNT_W-IDX_W){1'b0}}, idx_q};
	assign bad       = idx_ext >= active_q;

	always_comb begin
		if (valid_q[idx_q]) begin
			cur_state = ram_rdata;
		end else if (idx_ext >= active_q - kinit_q && idx_ext < active_q) begin
			cur_state = PS_INF;
		end else begin
			cur_state = PS_SUSC;
		end
	end

	always_comb begin
		new_state = cur_state;
		cnt_s_d = cnt_s_q;
		cnt_i_d = cnt_i_q;
		cnt_r_d = cnt_r_q;
		if (!bad) begin
			if (cur_state == PS_SUSC && {1'b0, draw_q} >= thr_q) begin
				new_state = PS_INF;
				cnt_s_d = cnt_s_q - 1'b1;
				cnt_i_d = cnt_i_q + 1'b1;
			end else if (cur_state == PS_INF && draw_q >= rec_stay_q) begin
				new_state = PS_REC;
				cnt_i_d = cnt_i_q - 1'b1;
				cnt_r_d = cnt_r_q + 1'b1;
			end
		end
	end

	assign ram_we = cmd.commit && !bad;

	smps_ram #(.WIDTH(2), .DEPTH(MAX_PEOPLE)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (new_state),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= RST_POP_SIZE;
			kinit_q  <= RST_INIT_INF;
			cnt_s_q  <= RST_POP_SIZE - RST_INIT_INF;
			cnt_i_q  <= RST_INIT_INF;
			cnt_r_q  <= '0;
			valid_q  <= '0;
			thr_q    <= RST_THRESHOLD;
		end else begin
			if (cmd.accept && req.req_type == REQ_RESTART) begin
				active_q <= p_new;
				kinit_q  <= k_new;
				cnt_s_q  <= p_new - k_new;
				cnt_i_q  <= k_new;
				cnt_r_q  <= '0;
				valid_q  <= '0;
			end else if (ram_we) begin
				cnt_s_q <= cnt_s_d;
				cnt_i_q <= cnt_i_d;
				cnt_r_q <= cnt_r_d;
				valid_q[idx_q] <= 1'b1;
			end
			if (cmd.thr_load) begin
				thr_q <= t_q;
			end
		end
	end

	assign product = t_q * inf_base_q;
	assign status.mul_done = (step_q == cnt_i_q) || (t_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q      <= req.person_index;
			draw_q     <= req.draw;
			t_q        <= PROB_ONE;
			step_q     <= '0;
		end else if (cmd.mul_step) begin
			t_q    <= product[PROB_BITS +: THR_W];
			step_q <= step_q + 1'b1;
		end
	end

	assign status.out_free = !rsp_valid || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.commit || cmd.finish) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp.person_state      <= bad ? PS_SUSC : new_state;
			rsp.count_susceptible <= cnt_s_d;
			rsp.count_infected    <= cnt_i_d;
			rsp.count_recovered   <= cnt_r_d;
			rsp.bad_index         <= bad;
		end else if (cmd.finish) begin
			rsp.person_state      <= PS_SUSC;
			rsp.count_susceptible <= cnt_s_q;
			rsp.count_infected    <= cnt_i_q;
			rsp.count_recovered   <= cnt_r_q;
			rsp.bad_index         <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/sir_markov_population_step_core.sv
// Stochastic SIR population, stepped one person at a time.
// Requests arrive as a req word on req_valid/req_stall; one rsp word leaves
// on rsp_valid/rsp_stall for every request, in order. A request is taken
// when req_valid is high and req_stall is low.
// A person update reads the person state memory on acceptance and writes
// it back when its result is loaded, which waits while the output register
// is full; the next request can be taken on the cycle after the result is
// loaded, so no new request is taken before an update is through.
// An end-of-tick or restart request runs the shared 17x16 multiplier once
// per infected person (stopping early if the product reaches zero); its
// result is loaded once the multiply ends and the output register is free.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, and writes belong between requests.
// Reset loads the default registers and the matching initial population:
// one hundred people with the last one infected.
// While rsp_stall is high the result word holds; the block may still take
// one more request and finish its work, then holds that result until the
// output register frees.
module sir_markov_population_step_core import smps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_word_t   req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_word_t   rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	smps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.status    (status),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	smps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

FILE: hw/rtl/smps_checker.sv
module smps_checker import smps_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_word_t rsp
);

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Result word changed while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ({2'b00, rsp.count_susceptible} + {2'b00, rsp.count_infected}
			+ {2'b00, rsp.count_recovered}) <= 10'(MAX_PEOPLE))
		else $error("Group counts exceed the population.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.person_state != 2'd3)
		else $error("Invalid person state reported.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_index |-> rsp.person_state == PS_SUSC)
		else $error("Rejected index reported a nonzero state.");

endmodule

bind sir_markov_population_step_core smps_checker u_smps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

FILE: test/sir_markov_population_step_core_tb.sv
`timescale 1ns / 1ps
module sir_markov_population_step_core_tb;
	import smps_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	class sir_shadow;
		logic [1:0]           people [MAX_PEOPLE];
		logic [7:0]           n_susc, n_inf, n_rec;
		logic [THR_W-1:0]     threshold;
		int unsigned          live_size;
		logic [7:0]           pop_size, init_inf;
		logic [PROB_BITS-1:0] base, rec_stay;
		rsp_word_t            awaited [$];
		int unsigned          mismatch_total;
		int unsigned          seen [4];
		int unsigned          infections, recoveries, rejected;

		function void set_register(logic [1:0] idx, logic [15:0] data);
			case (idx)
			CFG_POP_SIZE: pop_size = data[7:0];
			CFG_INIT_INF: init_inf = data[7:0];
			CFG_INF_BASE: base = data;
			CFG_REC_STAY: rec_stay = data;
			endcase
		endfunction

		// The threshold is base raised to the infected count, truncated after each step.
		function void recompute_threshold();
			logic [32:0] prod;
			int unsigned k;
			threshold = PROB_ONE;
			for (k = 0; k < n_inf && threshold != 0; k++) begin
				prod = threshold * base;
				threshold = prod[32:16];
			end
		endfunction

		function void restart_population();
			int unsigned p, k;
			p = (pop_size > MAX_PEOPLE) ? MAX_PEOPLE : pop_size;
			k = (init_inf > p) ? p : init_inf;
			for (int i = 0; i < MAX_PEOPLE; i++)
				people[i] = (i >= p - k && i < p) ? PS_INF : PS_SUSC;
			live_size = p;
			n_susc = 8'(p - k);
			n_inf = 8'(k);
			n_rec = 0;
			recompute_threshold();
		endfunction

		function void reset_state();
			pop_size = RST_POP_SIZE;
			init_inf = RST_INIT_INF;
			base = RST_INF_BASE;
			rec_stay = RST_REC_STAY;
			restart_population();
		endfunction

		function void take_request(req_word_t w);
			rsp_word_t e;
			logic [1:0] s;
			e = '0;
			seen[w.req_type]++;
			case (w.req_type)
			REQ_UPDATE: begin
				if (w.person_index >= live_size) begin
					e.bad_index = 1'b1;
					rejected++;
				end else begin
					s = people[w.person_index];
					if (s == PS_SUSC && {1'b0, w.draw} >= threshold) begin
						s = PS_INF;
						n_susc--;
						n_inf++;
						infections++;
					end else if (s == PS_INF && w.draw >= rec_stay) begin
						s = PS_REC;
						n_inf--;
						n_rec++;
						recoveries++;
					end
					people[w.person_index] = s;
					e.person_state = s;
				end
			end
			REQ_TICK: recompute_threshold();
			REQ_RESTART: restart_population();
			default: ;
			endcase
			e.count_susceptible = n_susc;
			e.count_infected = n_inf;
			e.count_recovered = n_rec;
			awaited.insert(awaited.size(), e);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				mismatch_total++;
			end
		endfunction

		function void match_word(rsp_word_t got);
			rsp_word_t e;
			if (awaited.size() == 0) begin
				$error("result word arrived with none outstanding: %p", got);
				mismatch_total++;
				return;
			end
			e = awaited.pop_front();
			compare_field("person_state", 8'(e.person_state), 8'(got.person_state));
			compare_field("count_susceptible", e.count_susceptible, got.count_susceptible);
			compare_field("count_infected", e.count_infected, got.count_infected);
			compare_field("count_recovered", e.count_recovered, got.count_recovered);
			compare_field("bad_index", 8'(e.bad_index), 8'(got.bad_index));
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_word_t   req;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_word_t   rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	sir_shadow   shadow = new();
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          stall_run = 0;
	int          reg_writes = 0;

	sir_markov_population_step_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			shadow.match_word(rsp);
		if (stall_run > 0) begin
			stall_run--;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_run = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(2);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(99) >= gap_pct)
			return 0;
		if ($urandom_range(19) == 0)
			return $urandom_range(50, 10);
		return $urandom_range(3, 1);
	endfunction

	function automatic logic [7:0] pick_size();
		case ($urandom_range(5))
		0: return 8'd1;
		1: return 8'd128;
		2: return 8'($urandom_range(255, 129));
		default: return 8'($urandom_range(128, 2));
		endcase
	endfunction

	function automatic logic [7:0] pick_seed(logic [7:0] size);
		int unsigned cap;
		cap = (size > MAX_PEOPLE) ? MAX_PEOPLE : size;
		case ($urandom_range(5))
		0: return 8'd0;
		1: return size;
		2: return 8'd255;
		default: return 8'($urandom_range(cap / 3));
		endcase
	endfunction

	function automatic logic [15:0] pick_prob();
		case ($urandom_range(5))
		0: return 16'h0000;
		1: return 16'hFFFF;
		2: return 16'($urandom);
		default: return 16'($urandom_range(65535, 60000));
		endcase
	endfunction

	task automatic send_request(logic [1:0] kind, logic [6:0] idx, logic [15:0] d);
		int gap;
		req_word_t w;
		w.req_type = kind;
		w.person_index = idx;
		w.draw = d;
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		shadow.take_request(w);
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (shadow.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		shadow.set_register(idx, d);
		reg_writes++;
	endtask

	task automatic close_config();
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [7:0] pop, logic [7:0] init, logic [15:0] b,
			logic [15:0] r);
		write_register(CFG_POP_SIZE, 16'(pop));
		write_register(CFG_INIT_INF, 16'(init));
		write_register(CFG_INF_BASE, b);
		write_register(CFG_REC_STAY, r);
		close_config();
	endtask

	task automatic random_update();
		logic [6:0] idx;
		logic [16:0] edge_val;
		logic [15:0] d;
		if (shadow.live_size == 0 || $urandom_range(99) < 12)
			idx = 7'($urandom_range(127));
		else
			idx = 7'($urandom_range(shadow.live_size - 1));
		if ($urandom_range(99) < 30) begin
			if (shadow.people[idx] == PS_INF)
				edge_val = {1'b0, shadow.rec_stay};
			else
				edge_val = (shadow.threshold > 17'hFFFF) ? 17'hFFFF : shadow.threshold;
			d = 16'(edge_val) - 16'($urandom_range(1));
		end else begin
			d = 16'($urandom);
		end
		send_request(REQ_UPDATE, idx, d);
	endtask

	initial begin
		int sent;
		int len;
		int r;
		bit wrote;
		logic [7:0] size;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		shadow.reset_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(REQ_TICK, 7'd0, 16'd0);
		send_request(REQ_UNUSED, 7'h7F, 16'hFFFF);
		send_request(REQ_UPDATE, 7'd0, 16'd0);
		send_request(REQ_UPDATE, 7'd0, RST_INF_BASE - 16'd1);
		send_request(REQ_UPDATE, 7'd0, RST_INF_BASE);
		send_request(REQ_UPDATE, 7'(RST_POP_SIZE - 1), 16'hFFFF);
		send_request(REQ_UPDATE, 7'(RST_POP_SIZE - 1), 16'd0);
		send_request(REQ_UPDATE, 7'(RST_POP_SIZE), 16'd0);
		send_request(REQ_UPDATE, 7'h7F, 16'hFFFF);
		send_request(REQ_UPDATE, 7'd0, RST_REC_STAY - 16'd1);
		send_request(REQ_UPDATE, 7'd0, RST_REC_STAY);
		send_request(REQ_TICK, 7'd0, 16'd0);
		send_request(REQ_UPDATE, 7'd1, 16'hFFFF);
		send_request(REQ_RESTART, 7'd0, 16'd0);
		wait_idle();
		configure(8'd255, 8'd255, 16'h0000, 16'h0000);
		send_request(REQ_RESTART, 7'd0, 16'd0);
		send_request(REQ_UPDATE, 7'h7F, 16'd0);
		send_request(REQ_TICK, 7'd0, 16'd0);
		wait_idle();
		configure(8'd1, 8'd0, 16'hFFFF, 16'hFFFF);
		send_request(REQ_RESTART, 7'd0, 16'd0);
		send_request(REQ_UPDATE, 7'd0, 16'hFFFF);
		send_request(REQ_UPDATE, 7'd1, 16'd0);
		send_request(REQ_TICK, 7'd0, 16'd0);
		wait_idle();
		configure(8'd0, 8'd0, RST_INF_BASE, RST_REC_STAY);
		send_request(REQ_RESTART, 7'd0, 16'd0);
		send_request(REQ_UPDATE, 7'd0, 16'd0);

		sent = 0;
		for (int phase = 0; sent < 1650; phase++) begin
			wait_idle();
			gap_pct = (phase == 0) ? 0 : 10 * $urandom_range(6);
			stall_pct = (phase == 0) ? 0 : 10 * $urandom_range(6);
			size = pick_size();
			wrote = 1'b0;
			if ($urandom_range(1)) begin
				write_register(CFG_POP_SIZE, 16'(size));
				wrote = 1'b1;
			end
			if ($urandom_range(1)) begin
				write_register(CFG_INIT_INF, 16'(pick_seed(shadow.pop_size)));
				wrote = 1'b1;
			end
			if ($urandom_range(1)) begin
				write_register(CFG_INF_BASE, pick_prob());
				wrote = 1'b1;
			end
			if ($urandom_range(1)) begin
				write_register(CFG_REC_STAY, pick_prob());
				wrote = 1'b1;
			end
			if (wrote)
				close_config();
			if ($urandom_range(9) < 7) begin
				send_request(REQ_RESTART, 7'($urandom_range(127)), 16'($urandom));
				sent++;
			end
			len = $urandom_range(220, 120);
			for (int n = 0; n < len && sent < 1650; n++) begin
				if (phase % 2 == 1 && n == len / 2)
					wait_idle();
				r = $urandom_range(99);
				if (r < 84)
					random_update();
				else if (r < 93)
					send_request(REQ_TICK, 7'($urandom_range(127)), 16'($urandom));
				else if (r < 96)
					send_request(REQ_RESTART, 7'($urandom_range(127)), 16'($urandom));
				else
					send_request(REQ_UNUSED, 7'($urandom_range(127)), 16'($urandom));
				sent++;
			end
		end

		gap_pct = 0;
		wait_idle();
		repeat (20) @(posedge clk);
		if (shadow.pending() != 0) begin
			$error("%0d result words never arrived", shadow.pending());
			shadow.mismatch_total++;
		end
		$display("Covered %0d person updates (%0d infections, %0d recoveries, %0d rejected).",
			shadow.seen[REQ_UPDATE], shadow.infections, shadow.recoveries, shadow.rejected);
		$display("Also %0d tick ends, %0d restarts, %0d unused requests, %0d register writes.",
			shadow.seen[REQ_TICK], shadow.seen[REQ_RESTART], shadow.seen[REQ_UNUSED],
			reg_writes);
		if (shadow.mismatch_total == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
